// ----- hdl/tisa_pkg.sv -----
// Shared types, constants and helpers for the tile id to sheet address block.
// No dependencies; imported by tisa_divider, tile_id_to_sheet_address and the testbench.
`default_nettype none

package tisa_pkg;

  // Sheets searched; the register file always holds four descriptors.
  localparam int NUM_SHEETS = 4;
  localparam int SHEET_REGS = 4;
  localparam int ID_BITS    = 16;

  localparam int TILE_ID_W  = 16;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_IDX_W  = 3;
  localparam int LAYER_W    = 9;   // layer size register, 1..256
  localparam int POS_W      = 8;   // layer position counters
  localparam int SC_W       = 3;   // sheet count register
  localparam int SEL_W      = 2;   // sheet index
  localparam int DIV_W      = 9;   // sheet columns, 1..256
  localparam int REM_W      = 8;   // remainder < 256
  localparam int PIX_W      = 8;
  localparam int ROW_W      = 16;
  localparam int DEST_W     = 16;
  localparam int CNT_W      = $clog2(ID_BITS);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LAYER_COLS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LAYER_ROWS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SET_COUNT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SHEET_0    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SHEET_1    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SHEET_2    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_SHEET_3    = 3'd6;

  // Sheet descriptor layout
  typedef struct packed {
    logic [PIX_W-1:0] pix;
    logic [7:0]       cols;    // 0 encodes 256
    logic [15:0]      count;
    logic [15:0]      last;
    logic [15:0]      first;
  } sheet_desc_t;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_SEARCH = 5'b00010,
    ST_LOAD   = 5'b00100,
    ST_DIVIDE = 5'b01000,
    ST_FINISH = 5'b10000
  } state_e;

  // Divider result toward the sequencer
  typedef struct packed {
    logic               done;
    logic [ID_BITS-1:0] quo;
    logic [REM_W-1:0]   rem;
  } div_res_t;

  function automatic logic [LAYER_W-1:0] clamp_layer(input logic [LAYER_W-1:0] v);
    logic [LAYER_W-1:0] r;
    r = v;
    if (v == '0) r = LAYER_W'(1);
    else if (v > LAYER_W'(256)) r = LAYER_W'(256);
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/tile_id_to_sheet_address.sv -----
// Top level: maps layer tile ids to tile-sheet addresses.
// Depends on tisa_pkg and tisa_divider.
//
// Usage
//   Input channel (in_valid_i/in_ready_o, tile_id_i) takes one tile id per
//   transaction in row-major layer order. Output channel (out_valid_o/
//   out_ready_i) returns one result per input transaction.
//   Configuration is written through cfg_we_i/cfg_index_i/cfg_data_i while
//   the block is idle; index 7 is ignored.
//   Steps: accept, one search step per sheet tried (up to NUM_SHEETS-1,
//   sheets from index 1; sheet 0 is the fallback), one descriptor load,
//   the divider run plus its done flag, and one finish step for a drawn
//   tile; an empty cell goes from accept straight to the finish step.
//   The restoring divider, one quotient bit per cycle, sets the rate.
//   in_ready_o is high only while the sequencer is idle; one result may sit
//   in the output register while the next tile is worked on. A stalled
//   receiver holds the sequencer in its finish step until the register
//   frees up.
//   Reset clears the layer position to 0, sets layer size 1x1, one sheet,
//   and all sheet descriptors to 0.
`default_nettype none

module tile_id_to_sheet_address (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [tisa_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [tisa_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                            in_valid_i,
  output      logic                            in_ready_o,
  input  wire logic [tisa_pkg::TILE_ID_W-1:0]  tile_id_i,
  output      logic                            out_valid_o,
  input  wire logic                            out_ready_i,
  output      logic                            draw_o,
  output      logic [tisa_pkg::SEL_W-1:0]      sheet_index_o,
  output      logic [tisa_pkg::ROW_W-1:0]      src_row_o,
  output      logic [tisa_pkg::REM_W-1:0]      src_col_o,
  output      logic [tisa_pkg::DEST_W-1:0]     dest_x_o,
  output      logic [tisa_pkg::DEST_W-1:0]     dest_y_o,
  output      logic [tisa_pkg::PIX_W-1:0]      tile_pixels_o,
  output      logic                            layer_done_o
);
  import tisa_pkg::*;

  // Configuration registers
  logic [LAYER_W-1:0] layer_cols_q, layer_rows_q;
  logic [SC_W-1:0]    set_count_q;
  sheet_desc_t        sheet_q [SHEET_REGS];

  // Sequencer state
  state_e             state_q, state_d;
  logic [POS_W-1:0]   cur_col_q, cur_col_d, cur_row_q, cur_row_d;
  logic [ID_BITS-1:0] id_q, id_d, rid_q, rid_d;
  logic [POS_W-1:0]   col_q, col_d, row_q, row_d;
  logic               done_flag_q, done_flag_d;
  logic               empty_q, empty_d;
  logic [SEL_W-1:0]   k_q, k_d, sel_q, sel_d;
  logic [PIX_W-1:0]   pix_q, pix_d;

  // Output register
  logic               out_valid_q, out_valid_d;
  logic               draw_q;
  logic [SEL_W-1:0]   sheet_index_q;
  logic [ROW_W-1:0]   src_row_q;
  logic [REM_W-1:0]   src_col_q;
  logic [DEST_W-1:0]  dest_x_q, dest_y_q;
  logic [PIX_W-1:0]   tile_pixels_q;
  logic               layer_done_q;
  logic               out_load;

  logic [LAYER_W-1:0] cols_l, rows_l;
  logic               last_col, last_row;
  logic [SC_W-1:0]    sc_eff;
  logic               in_acc;
  logic [ID_BITS-1:0] id_in;
  logic [SEL_W-1:0]   rd_idx;
  sheet_desc_t        rd_desc;
  logic [15:0]        id_ext;
  logic               hit;
  logic [15:0]        rebase;
  logic               search_end;
  logic               div_start;
  logic [DIV_W-1:0]   div_cols;
  logic [ID_BITS-1:0] div_idx;
  div_res_t           div_res;

  // ---------------- configuration ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      layer_cols_q <= LAYER_W'(1);
      layer_rows_q <= LAYER_W'(1);
      set_count_q  <= SC_W'(1);
      for (int i = 0; i < SHEET_REGS; i++) sheet_q[i] <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_LAYER_COLS: layer_cols_q <= cfg_data_i[LAYER_W-1:0];
        CFG_LAYER_ROWS: layer_rows_q <= cfg_data_i[LAYER_W-1:0];
        CFG_SET_COUNT:  set_count_q  <= cfg_data_i[SC_W-1:0];
        CFG_SHEET_0:    sheet_q[0]   <= sheet_desc_t'(cfg_data_i);
        CFG_SHEET_1:    sheet_q[1]   <= sheet_desc_t'(cfg_data_i);
        CFG_SHEET_2:    sheet_q[2]   <= sheet_desc_t'(cfg_data_i);
        CFG_SHEET_3:    sheet_q[3]   <= sheet_desc_t'(cfg_data_i);
        default: ;
      endcase
    end
  end

  assign cols_l   = clamp_layer(layer_cols_q);
  assign rows_l   = clamp_layer(layer_rows_q);
  assign last_col = ({1'b0, cur_col_q} + LAYER_W'(1)) >= cols_l;
  assign last_row = ({1'b0, cur_row_q} + LAYER_W'(1)) >= rows_l;

  always_comb begin
    sc_eff = set_count_q;
    if (set_count_q == '0) sc_eff = SC_W'(1);
    else if (set_count_q > SC_W'(NUM_SHEETS)) sc_eff = SC_W'(NUM_SHEETS);
  end

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign id_in      = tile_id_i[ID_BITS-1:0];

  // Single descriptor read port: search counter while searching, else selection
  assign rd_idx  = (state_q == ST_SEARCH) ? k_q : sel_q;
  assign rd_desc = sheet_q[rd_idx];

  assign id_ext     = 16'(id_q);
  assign hit        = (id_ext >= rd_desc.first) && (id_ext <= rd_desc.last);
  assign rebase     = id_ext + rd_desc.count - rd_desc.last;
  assign search_end = ({1'b0, k_q} + SC_W'(1)) >= sc_eff;

  assign div_cols  = (rd_desc.cols == '0) ? DIV_W'(256) : {1'b0, rd_desc.cols};
  assign div_idx   = rid_q - ID_BITS'(1);
  assign div_start = (state_q == ST_LOAD);

  tisa_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_idx),
    .divisor_i  (div_cols),
    .res_o      (div_res)
  );

  // ---------------- sequencer ----------------
  always_comb begin
    state_d     = state_q;
    cur_col_d   = cur_col_q;
    cur_row_d   = cur_row_q;
    id_d        = id_q;
    rid_d       = rid_q;
    col_d       = col_q;
    row_d       = row_q;
    done_flag_d = done_flag_q;
    empty_d     = empty_q;
    k_d         = k_q;
    sel_d       = sel_q;
    pix_d       = pix_q;
    out_load    = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          id_d        = id_in;
          rid_d       = id_in;
          col_d       = cur_col_q;
          row_d       = cur_row_q;
          done_flag_d = last_col && last_row;
          empty_d     = (id_in == '0);
          k_d         = SEL_W'(1);
          sel_d       = '0;
          if (last_col) begin
            cur_col_d = '0;
            cur_row_d = last_row ? '0 : cur_row_q + POS_W'(1);
          end else begin
            cur_col_d = cur_col_q + POS_W'(1);
          end
          if (id_in == '0) state_d = ST_FINISH;
          else if (sc_eff <= SC_W'(1)) state_d = ST_LOAD;
          else state_d = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (hit) begin
          rid_d   = rebase[ID_BITS-1:0];
          sel_d   = k_q;
          state_d = ST_LOAD;
        end else if (search_end) begin
          state_d = ST_LOAD;
        end else begin
          k_d = k_q + SEL_W'(1);
        end
      end
      ST_LOAD: begin
        pix_d   = rd_desc.pix;
        state_d = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        if (div_res.done) state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cur_col_q   <= '0;
      cur_row_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cur_col_q   <= cur_col_d;
      cur_row_q   <= cur_row_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q        <= id_d;
    rid_q       <= rid_d;
    col_q       <= col_d;
    row_q       <= row_d;
    done_flag_q <= done_flag_d;
    empty_q     <= empty_d;
    k_q         <= k_d;
    sel_q       <= sel_d;
    pix_q       <= pix_d;
  end

  // Result register; 8x8 products for the destination position
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      layer_done_q <= done_flag_q;
      if (empty_q) begin
        draw_q        <= 1'b0;
        sheet_index_q <= '0;
        src_row_q     <= '0;
        src_col_q     <= '0;
        dest_x_q      <= '0;
        dest_y_q      <= '0;
        tile_pixels_q <= '0;
      end else begin
        draw_q        <= 1'b1;
        sheet_index_q <= sel_q;
        src_row_q     <= ROW_W'(div_res.quo);
        src_col_q     <= div_res.rem;
        dest_x_q      <= DEST_W'(col_q * pix_q);
        dest_y_q      <= DEST_W'(row_q * pix_q);
        tile_pixels_q <= pix_q;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign draw_o        = draw_q;
  assign sheet_index_o = sheet_index_q;
  assign src_row_o     = src_row_q;
  assign src_col_o     = src_col_q;
  assign dest_x_o      = dest_x_q;
  assign dest_y_o      = dest_y_q;
  assign tile_pixels_o = tile_pixels_q;
  assign layer_done_o  = layer_done_q;

endmodule

`default_nettype wire

// ----- hdl/tisa_divider.sv -----
// Restoring divider, one quotient bit per cycle, for sheet row/column split.
// Depends on tisa_pkg.
`default_nettype none

module tisa_divider (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  input  wire logic [tisa_pkg::ID_BITS-1:0] dividend_i,
  input  wire logic [tisa_pkg::DIV_W-1:0]   divisor_i,
  output tisa_pkg::div_res_t                res_o
);
  import tisa_pkg::*;

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [ID_BITS-1:0]  quo_q, quo_d;
  logic [DIV_W-1:0]    rem_q, rem_d;   // partial remainder, always < divisor
  logic [DIV_W-1:0]    dvs_q, dvs_d;
  logic [DIV_W:0]      trial;
  logic [DIV_W:0]      diff;
  logic                fits;

  assign trial = {rem_q, quo_q[ID_BITS-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign fits  = trial >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(ID_BITS - 1);
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      quo_d = {quo_q[ID_BITS-2:0], fits};
      rem_d = fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign res_o.done = done_q;
  assign res_o.quo  = quo_q;
  assign res_o.rem  = rem_q[REM_W-1:0];

endmodule

`default_nettype wire

// ----- tb/tisa_checker.sv -----
`timescale 1ns / 100ps
// Scoreboard for tile_id_to_sheet_address: mirrors register writes, predicts
// the sheet address of every accepted tile id and checks the result stream.
// Depends on tisa_pkg.
module tisa_checker (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [tisa_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [tisa_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                            in_valid_i,
  input  wire logic                            in_ready_i,
  input  wire logic [tisa_pkg::TILE_ID_W-1:0]  tile_id_i,
  input  wire logic                            out_valid_i,
  input  wire logic                            out_ready_i,
  input  wire logic                            draw_i,
  input  wire logic [tisa_pkg::SEL_W-1:0]      sheet_index_i,
  input  wire logic [tisa_pkg::ROW_W-1:0]      src_row_i,
  input  wire logic [tisa_pkg::REM_W-1:0]      src_col_i,
  input  wire logic [tisa_pkg::DEST_W-1:0]     dest_x_i,
  input  wire logic [tisa_pkg::DEST_W-1:0]     dest_y_i,
  input  wire logic [tisa_pkg::PIX_W-1:0]      tile_pixels_i,
  input  wire logic                            layer_done_i,
  output int                                   fail_count_o,
  output int                                   pending_o,
  output int                                   checked_o,
  output int                                   drawn_o,
  output int                                   layer_ends_o
);
  import tisa_pkg::*;

  typedef struct packed {
    logic              draw;
    logic [SEL_W-1:0]  sheet;
    logic [ROW_W-1:0]  row;
    logic [REM_W-1:0]  col;
    logic [DEST_W-1:0] dx;
    logic [DEST_W-1:0] dy;
    logic [PIX_W-1:0]  pix;
    logic              done;
  } tile_addr_t;

  logic [LAYER_W-1:0] layer_cols_q;
  logic [LAYER_W-1:0] layer_rows_q;
  logic [SC_W-1:0]    set_count_q;
  sheet_desc_t        sheet_q [SHEET_REGS];
  logic [POS_W-1:0]   pos_col_q;
  logic [POS_W-1:0]   pos_row_q;
  tile_addr_t         expected_addr_q [$];
  tile_addr_t         seen;
  tile_addr_t         want;

  function automatic string addr_str(input tile_addr_t a);
    return $sformatf("draw=%0d sheet=%0d row=%0d col=%0d x=%0d y=%0d pix=%0d done=%0d",
                     a.draw, a.sheet, a.row, a.col, a.dx, a.dy, a.pix, a.done);
  endfunction

  task automatic note_failure(input string msg);
    fail_count_o++;
    if (fail_count_o <= 10) begin
      $display("%0t: %s", $time, msg);
    end
  endtask

  // Address of one tile id at the current layer position; advances the position.
  task automatic predict_address(input logic [TILE_ID_W-1:0] tile_id,
                                 output tile_addr_t res);
    int                 cols_eff;
    int                 rows_eff;
    int                 sheets_eff;
    int                 sheet_cols;
    int                 k;
    logic [ID_BITS-1:0] rebased;
    logic [ID_BITS-1:0] offset;
    logic [SEL_W-1:0]   sel;
    bit                 hit;
    bit                 end_col;
    bit                 end_row;
    sheet_desc_t        d;
    cols_eff = (layer_cols_q == 0) ? 1 : (layer_cols_q > 256) ? 256 : int'(layer_cols_q);
    rows_eff = (layer_rows_q == 0) ? 1 : (layer_rows_q > 256) ? 256 : int'(layer_rows_q);
    sheets_eff = (set_count_q == 0) ? 1 : int'(set_count_q);
    if (sheets_eff > NUM_SHEETS) sheets_eff = NUM_SHEETS;
    end_col = int'(pos_col_q) + 1 >= cols_eff;
    end_row = int'(pos_row_q) + 1 >= rows_eff;
    res = '0;
    sel = '0;
    rebased = tile_id;
    hit = 1'b0;
    if (tile_id != '0) begin
      // first sheet from index 1 in order whose inclusive range holds the id wins, else sheet 0
      for (k = 1; k < sheets_eff && !hit; k++) begin
        d = sheet_q[k];
        if (tile_id >= d.first && tile_id <= d.last) begin
          rebased = tile_id + d.count - d.last;   // wraps on a bad descriptor
          sel = SEL_W'(k);
          hit = 1'b1;
        end
      end
      d = sheet_q[sel];
      sheet_cols = (d.cols == 0) ? 256 : int'(d.cols);
      offset = rebased - 1'b1;
      res.draw  = 1'b1;
      res.sheet = sel;
      res.row   = ROW_W'(int'(offset) / sheet_cols);
      res.col   = REM_W'(int'(offset) % sheet_cols);
      res.dx    = DEST_W'(pos_col_q) * DEST_W'(d.pix);
      res.dy    = DEST_W'(pos_row_q) * DEST_W'(d.pix);
      res.pix   = d.pix;
    end
    res.done = end_col && end_row;
    if (end_col) begin
      pos_col_q = '0;
      pos_row_q = end_row ? '0 : pos_row_q + 1'b1;
    end else begin
      pos_col_q = pos_col_q + 1'b1;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      layer_cols_q = LAYER_W'(1);
      layer_rows_q = LAYER_W'(1);
      set_count_q  = SC_W'(1);
      for (int k = 0; k < SHEET_REGS; k++) sheet_q[k] = '0;
      pos_col_q = '0;
      pos_row_q = '0;
      expected_addr_q.delete();
      fail_count_o = 0;
      pending_o    = 0;
      checked_o    = 0;
      drawn_o      = 0;
      layer_ends_o = 0;
    end else begin
      // results before new tiles, so a same-cycle transaction pair pops the older one
      if (out_valid_i && out_ready_i) begin
        seen = {draw_i, sheet_index_i, src_row_i, src_col_i, dest_x_i, dest_y_i,
                tile_pixels_i, layer_done_i};
        checked_o++;
        if (expected_addr_q.size() == 0) begin
          note_failure($sformatf("result with no tile pending: %s", addr_str(seen)));
        end else begin
          want = expected_addr_q.pop_front();
          if (seen.draw !== want.draw || seen.sheet !== want.sheet ||
              seen.row !== want.row || seen.col !== want.col ||
              seen.dx !== want.dx || seen.dy !== want.dy ||
              seen.pix !== want.pix || seen.done !== want.done) begin
            note_failure($sformatf("mismatch\n  expected %s\n  actual   %s",
                                   addr_str(want), addr_str(seen)));
          end
          if (want.draw) drawn_o++;
          if (want.done) layer_ends_o++;
        end
      end
      if (in_valid_i && in_ready_i) begin
        predict_address(tile_id_i, want);
        expected_addr_q.push_back(want);
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_LAYER_COLS: layer_cols_q = cfg_data_i[LAYER_W-1:0];
          CFG_LAYER_ROWS: layer_rows_q = cfg_data_i[LAYER_W-1:0];
          CFG_SET_COUNT:  set_count_q  = cfg_data_i[SC_W-1:0];
          CFG_SHEET_0:    sheet_q[0]   = cfg_data_i;
          CFG_SHEET_1:    sheet_q[1]   = cfg_data_i;
          CFG_SHEET_2:    sheet_q[2]   = cfg_data_i;
          CFG_SHEET_3:    sheet_q[3]   = cfg_data_i;
          default: ;
        endcase
      end
      pending_o = expected_addr_q.size();
    end
  end

endmodule

// ----- tb/tb_tile_id_to_sheet_address.sv -----
`timescale 1ns / 100ps
// Testbench top for tile_id_to_sheet_address: drives tile ids and register
// layouts, randomizes both handshakes and reports the verdict.
// Depends on tisa_pkg, tile_id_to_sheet_address and tisa_checker.
module tb_tile_id_to_sheet_address;
  import tisa_pkg::*;

  localparam int                   STALL_LIMIT   = 4000;
  localparam int                   SETTLE_CYCLES = 30;
  localparam int                   IDLE_PCT      = 33;
  localparam int                   RANDOM_PHASES = 8;
  localparam int                   PHASE_ITEMS   = 225;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED    = 3'd7;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;
  logic                  in_valid_i  = 1'b0;
  logic [TILE_ID_W-1:0]  tile_id_i   = '0;
  logic                  out_ready_i = 1'b0;
  logic                  in_ready_o;
  logic                  out_valid_o;
  logic                  draw_o;
  logic [SEL_W-1:0]      sheet_index_o;
  logic [ROW_W-1:0]      src_row_o;
  logic [REM_W-1:0]      src_col_o;
  logic [DEST_W-1:0]     dest_x_o;
  logic [DEST_W-1:0]     dest_y_o;
  logic [PIX_W-1:0]      tile_pixels_o;
  logic                  layer_done_o;

  int          fail_count;
  int          pending;
  int          checked;
  int          drawn;
  int          layer_ends;
  int          tiles_sent   = 0;
  int          layouts      = 0;
  int          stall_cycles = 0;
  int          sheets_live  = 1;
  bit          calm         = 1'b0;
  sheet_desc_t sheet_cfg [SHEET_REGS];

  always #1 clk_i = ~clk_i;

  tile_id_to_sheet_address u_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_ready_o, .tile_id_i,
    .out_valid_o, .out_ready_i,
    .draw_o, .sheet_index_o, .src_row_o, .src_col_o,
    .dest_x_o, .dest_y_o, .tile_pixels_o, .layer_done_o
  );

  tisa_checker u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_ready_i(in_ready_o), .tile_id_i,
    .out_valid_i(out_valid_o), .out_ready_i,
    .draw_i(draw_o), .sheet_index_i(sheet_index_o), .src_row_i(src_row_o),
    .src_col_i(src_col_o), .dest_x_i(dest_x_o), .dest_y_i(dest_y_o),
    .tile_pixels_i(tile_pixels_o), .layer_done_i(layer_done_o),
    .fail_count_o(fail_count), .pending_o(pending), .checked_o(checked),
    .drawn_o(drawn), .layer_ends_o(layer_ends)
  );

  // result side backpressure
  always @(posedge clk_i) begin
    out_ready_i <= calm || ($urandom_range(99) >= IDLE_PCT);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("no transaction for %0d cycles, %0d results pending", stall_cycles, pending);
      $display("tb_tile_id_to_sheet_address failed");
      $finish;
    end
  end

  function automatic sheet_desc_t pack_sheet(input int first, input int last,
                                             input int count, input int cols, input int pix);
    sheet_desc_t d;
    d.first = 16'(first);
    d.last  = 16'(last);
    d.count = 16'(count);
    d.cols  = 8'(cols);
    d.pix   = PIX_W'(pix);
    return d;
  endfunction

  function automatic sheet_desc_t random_sheet();
    int first;
    int count;
    // a share of arbitrary descriptors, ranges and counts inconsistent
    if ($urandom_range(99) < 15) return {$urandom, $urandom};
    first = $urandom_range(60000, 1);
    count = ($urandom_range(3) == 0) ? $urandom_range(4000, 1) : $urandom_range(64, 1);
    if (first + count - 1 > 65535) count = 65536 - first;
    return pack_sheet(first, first + count - 1, count, $urandom_range(255),
                      $urandom_range(255));
  endfunction

  function automatic logic [LAYER_W-1:0] pick_layer_size();
    case ($urandom_range(9))
      0:       return '0;
      1:       return LAYER_W'(1);
      2:       return LAYER_W'(256);
      3:       return LAYER_W'($urandom_range(511, 257));
      4:       return LAYER_W'($urandom);
      default: return LAYER_W'($urandom_range(12, 2));
    endcase
  endfunction

  function automatic logic [SC_W-1:0] pick_set_count();
    if ($urandom_range(99) < 55) return SC_W'(NUM_SHEETS);
    return SC_W'($urandom);
  endfunction

  // mostly ids inside a live sheet's range, some empty cells, some anywhere
  function automatic logic [TILE_ID_W-1:0] pick_tile_id();
    int          roll;
    sheet_desc_t d;
    roll = $urandom_range(99);
    if (roll < 12) return '0;
    if (roll < 72) begin
      d = sheet_cfg[$urandom_range(sheets_live - 1)];
      if (d.last < d.first) return TILE_ID_W'($urandom);
      case ($urandom_range(3))
        0:       return d.first;
        1:       return d.last;
        default: return TILE_ID_W'($urandom_range(d.last, d.first));
      endcase
    end
    return TILE_ID_W'($urandom);
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic apply_layout(input logic [LAYER_W-1:0] cols, input logic [LAYER_W-1:0] rows,
                              input logic [SC_W-1:0] count);
    int k;
    write_reg(CFG_LAYER_COLS, CFG_DATA_W'(cols));
    write_reg(CFG_LAYER_ROWS, CFG_DATA_W'(rows));
    write_reg(CFG_SET_COUNT, CFG_DATA_W'(count));
    for (k = 0; k < SHEET_REGS; k++) begin
      write_reg(CFG_IDX_W'(CFG_SHEET_0 + k), sheet_cfg[k]);
    end
    sheets_live = (count == 0) ? 1 : (count > NUM_SHEETS) ? NUM_SHEETS : int'(count);
    layouts++;
  endtask

  // entered and left right after a rising edge
  task automatic send_tile(input logic [TILE_ID_W-1:0] id);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    tile_id_i  <= id;
    @(negedge clk_i);
    while (!in_ready_o) @(negedge clk_i);
    @(posedge clk_i);
    tiles_sent++;
  endtask

  // hold the sender until every result is back, then let the block settle
  task automatic drain();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    int ph;
    int n;
    int k;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset layout: 1x1 layer, one sheet, all descriptors zero
    send_tile('0);
    send_tile(16'd1);
    send_tile('1);
    drain();

    sheet_cfg[0] = pack_sheet(0, 0, 0, 16, 8);
    sheet_cfg[1] = pack_sheet(1, 100, 100, 10, 16);
    sheet_cfg[2] = pack_sheet(101, 300, 200, 0, 32);   // 256 columns
    sheet_cfg[3] = pack_sheet(301, 400, 50, 7, 255);   // count disagrees with range
    write_reg(CFG_UNUSED, '1);
    apply_layout(LAYER_W'(3), LAYER_W'(2), SC_W'(4));
    send_tile('0);
    send_tile(16'd1);
    send_tile(16'd100);
    send_tile(16'd101);
    send_tile(16'd300);
    send_tile(16'd301);
    send_tile(16'd350);   // rebases to zero
    send_tile(16'd400);
    send_tile(16'd401);   // misses every range, falls back to sheet 0
    send_tile(16'h5555);
    send_tile(16'hAAAA);
    send_tile(16'h8000);
    send_tile(16'hFFFF);
    drain();

    // out-of-range layer sizes and sheet counts
    apply_layout('0, '1, '0);
    send_tile(16'd1);
    send_tile(16'd150);
    send_tile('0);
    send_tile(16'hFFFF);
    drain();
    apply_layout('1, '0, '1);
    send_tile(16'd350);
    send_tile(16'd101);
    send_tile(16'd400);
    drain();

    for (ph = 0; ph < RANDOM_PHASES; ph++) begin
      calm = (ph == 2);
      for (k = 0; k < SHEET_REGS; k++) sheet_cfg[k] = random_sheet();
      if ($urandom_range(1)) write_reg(CFG_UNUSED, {$urandom, $urandom});
      apply_layout(pick_layer_size(), pick_layer_size(), pick_set_count());
      for (n = 0; n < PHASE_ITEMS; n++) begin
        send_tile(pick_tile_id());
        if (ph == 1 && n == PHASE_ITEMS / 2) drain();
      end
      drain();
    end
    calm = 1'b0;

    $display("%0d tile ids sent across %0d register layouts, random handshake gaps",
             tiles_sent, layouts);
    $display("%0d results checked: %0d drawn tiles, %0d layer ends, %0d failures",
             checked, drawn, layer_ends, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("tb_tile_id_to_sheet_address passed");
    end else begin
      $display("tb_tile_id_to_sheet_address failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/tisa_pkg.sv
hdl/tisa_divider.sv
hdl/tile_id_to_sheet_address.sv
tb/tisa_checker.sv
tb/tb_tile_id_to_sheet_address.sv
